// ===== sv/reader_writer_lock_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Reader/writer lock unit - assertion macros
// Shorthand for clocked assertions; expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef READER_WRITER_LOCK_UNIT_ASSERT_SVH
`define READER_WRITER_LOCK_UNIT_ASSERT_SVH

// plain invariant, checked every cycle outside reset
`define RWL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RWL_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWL_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader/writer lock unit - package
// Request modes, result codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package rwl_pkg;

  // request modes
  localparam logic [1:0] MODE_QUERY   = 2'd0;
  localparam logic [1:0] MODE_LOCK    = 2'd1;
  localparam logic [1:0] MODE_UNLOCK  = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // answers; ANS_NONE doubles as "free" and "refused"
  localparam logic [2:0] ANS_NONE        = 3'd0;
  localparam logic [2:0] ANS_SUCCESS     = 3'd1;
  localparam logic [2:0] ANS_OWN_WRITE   = 3'd1;
  localparam logic [2:0] ANS_OTHER_WRITE = 3'd2;
  localparam logic [2:0] ANS_OWN_READ    = 3'd3;
  localparam logic [2:0] ANS_OTHERS_READ = 3'd4;

  // error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_MODE = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic commit;
  } rwl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic hit;
    logic walk_end;
    logic need_shift;
    logic out_busy;
  } rwl_sts_t;

endpackage

// ===== sv/rwl_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader/writer lock unit - request channel
// Valid/ready channel carrying one lock request per transfer.
// ----------------------------------------------------------------------------
interface rwl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] requester;
  logic       read_only;

  modport source (output valid, output mode, output requester, output read_only,
                  input ready);
  modport sink   (input valid, input mode, input requester, input read_only,
                  output ready);
endinterface

// ===== sv/rwl_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader/writer lock unit - response channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface rwl_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] answer;
  logic [1:0] error_code;

  modport source (output valid, output answer, output error_code, input ready);
  modport sink   (input valid, input answer, input error_code, output ready);
endinterface

// ===== sv/rwl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader/writer lock unit - generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module rwl_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rwl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader/writer lock unit - controller
// Sequences accept, reader scan, list compaction and commit.
// ----------------------------------------------------------------------------
module rwl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  rwl_pkg::rwl_sts_t sts_i,
  output rwl_pkg::rwl_cmd_t cmd_o
);
  import rwl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.need_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit || sts_i.walk_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.need_shift) begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.walk_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/rwl_dp.sv =====
`timescale 1ns / 1ps
`include "reader_writer_lock_unit_assert.svh"
// ----------------------------------------------------------------------------
// Reader/writer lock unit - datapath
// Lock state, reader-id RAM walker and the result register.
// ----------------------------------------------------------------------------
module rwl_dp #(
  parameter int unsigned MAX_READERS = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rwl_pkg::rwl_cmd_t cmd_i,
  output rwl_pkg::rwl_sts_t sts_o,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        requester_i,
  input  logic              read_only_i,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output logic [2:0]        answer_o,
  output logic [1:0]        error_code_o
);
  import rwl_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_READERS + 1);
  localparam int unsigned AW    = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;

  // captured request
  logic [1:0]         mode_q;
  logic [ID_BITS-1:0] who_q;
  logic               ro_q;

  // lock state
  logic               held_q, held_d;
  logic [ID_BITS-1:0] writer_q, writer_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // list walker
  logic [CNT_W-1:0]   ptr_q;
  logic               pend_q;
  logic [AW-1:0]      pend_addr_q;
  logic               found_q;
  logic [AW-1:0]      pos_q;

  // result register
  logic               out_valid_q;
  logic [2:0]         answer_q, answer_d;
  logic [1:0]         err_q, err_d;

  // RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic [ID_BITS-1:0] ram_rdata;

  // commit-time list write
  logic               c_we;
  logic [AW-1:0]      c_waddr;

  logic               hit;
  logic               walk_end;
  logic               ptr_live;

  rwl_ram #(
    .WIDTH  (ID_BITS),
    .DEPTH  (MAX_READERS),
    .ADDR_W (AW)
  ) u_ids (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ptr_live = (ptr_q < count_q);
  assign hit      = pend_q && (ram_rdata == who_q);
  assign walk_end = (ptr_q == count_q) && !pend_q;

  assign sts_o.need_scan  = (mode_q != MODE_INVALID) && !held_q && (count_q != '0);
  assign sts_o.hit        = hit;
  assign sts_o.walk_end   = walk_end;
  assign sts_o.need_shift = (mode_q == MODE_UNLOCK) && found_q;
  assign sts_o.out_busy   = out_valid_q && !rsp_ready_i;

  // outcome of the request, applied on commit
  always_comb begin
    held_d   = held_q;
    writer_d = writer_q;
    count_d  = count_q;
    answer_d = ANS_NONE;
    err_d    = ERR_OK;
    c_we     = 1'b0;
    c_waddr  = '0;
    unique case (mode_q)
      MODE_QUERY: begin
        if (held_q) begin
          answer_d = (writer_q == who_q) ? ANS_OWN_WRITE : ANS_OTHER_WRITE;
        end else if (count_q != '0) begin
          answer_d = found_q ? ANS_OWN_READ : ANS_OTHERS_READ;
        end
      end
      MODE_LOCK: begin
        if (ro_q) begin
          if (held_q) begin
            if (writer_q == who_q) begin
              // demote own write lock
              c_we     = 1'b1;
              c_waddr  = '0;
              count_d  = CNT_W'(1);
              held_d   = 1'b0;
              answer_d = ANS_SUCCESS;
            end
          end else if (found_q) begin
            answer_d = ANS_SUCCESS;
          end else if (count_q == CNT_W'(MAX_READERS)) begin
            err_d = ERR_FULL;
          end else begin
            c_we     = 1'b1;
            c_waddr  = count_q[AW-1:0];
            count_d  = count_q + CNT_W'(1);
            answer_d = ANS_SUCCESS;
          end
        end else begin
          if (count_q == '0) begin
            if (!held_q) begin
              writer_d = who_q;
              held_d   = 1'b1;
              answer_d = ANS_SUCCESS;
            end else if (writer_q == who_q) begin
              answer_d = ANS_SUCCESS;
            end
          end else if ((count_q == CNT_W'(1)) && found_q) begin
            // promote sole read lock
            count_d  = '0;
            writer_d = who_q;
            held_d   = 1'b1;
            answer_d = ANS_SUCCESS;
          end
        end
      end
      MODE_UNLOCK: begin
        answer_d = ANS_SUCCESS;
        if (held_q) begin
          if (writer_q == who_q) begin
            held_d = 1'b0;
          end
        end else if (found_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      MODE_INVALID: begin
        err_d = ERR_MODE;
      end
    endcase
  end

  // compaction writes follow their read in the next cycle, one slot lower
  always_comb begin
    if (cmd_i.shift_step && pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q - AW'(1);
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = cmd_i.commit && c_we;
      ram_waddr = c_waddr;
      ram_wdata = who_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      writer_q    <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_step && hit) begin
        found_q <= 1'b1;
      end

      if (cmd_i.scan_start) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.shift_start) begin
        ptr_q  <= CNT_W'(pos_q) + CNT_W'(1);
        pend_q <= 1'b0;
      end else if (cmd_i.scan_step || cmd_i.shift_step) begin
        if (ptr_live) begin
          ptr_q  <= ptr_q + CNT_W'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end

      if (cmd_i.commit) begin
        held_q      <= held_d;
        writer_q    <= writer_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      who_q  <= ID_BITS'(requester_i);
      ro_q   <= read_only_i;
    end
    if ((cmd_i.scan_step || cmd_i.shift_step) && ptr_live) begin
      pend_addr_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.scan_step && hit) begin
      pos_q <= pend_addr_q;
    end
    if (cmd_i.commit) begin
      answer_q <= answer_d;
      err_q    <= err_d;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign answer_o     = answer_q;
  assign error_code_o = err_q;

  `RWL_ASSERT(a_rw_exclusive, !(held_q && (count_q != '0)), "write and read locks coexist")
  `RWL_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_READERS), "reader count overflow")
  `RWL_IMPLY(a_commit_free, cmd_i.commit, !(out_valid_q && !rsp_ready_i), "result overwritten")
  `RWL_NEXT(a_commit_shown, cmd_i.commit, out_valid_q, "committed result not presented")

endmodule

// ===== sv/reader_writer_lock_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader/writer lock unit - top level
// Single-object reader/writer lock with a packed reader-id list in RAM.
// ----------------------------------------------------------------------------
// Takes one request at a time: query, lock or unlock, each answered by exactly
// one response transfer. A request needing no list search skips the scan and
// goes straight to commit. A request that consults the list walks it in slot
// order; the search stops at the first match. An unlock that removes a reader
// at slot P then moves the later entries down one slot each. The unit returns
// to idle before the next request transfer. The search and compaction are
// bounded by the single read port of the reader-id RAM, walked one entry per
// cycle. The result sits in an output register, so a new request can be taken
// while the previous result waits; a new result is committed only once the
// previous one has been taken.
// ----------------------------------------------------------------------------
module reader_writer_lock_unit #(
  parameter int unsigned MAX_READERS = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rwl_req_if.sink   req_i,
  rwl_rsp_if.source rsp_o
);
  import rwl_pkg::*;

  // control/status link between sequencer and datapath
  rwl_cmd_t cmd;
  rwl_sts_t sts;

  // sequencer: owns the request handshake and the walk/commit ordering
  rwl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: lock state, reader list, result register
  rwl_dp #(
    .MAX_READERS (MAX_READERS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (req_i.mode),
    .requester_i  (req_i.requester),
    .read_only_i  (req_i.read_only),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .answer_o     (rsp_o.answer),
    .error_code_o (rsp_o.error_code)
  );

endmodule
